[rtl/core/cdm_pkg.sv]
// Shared types and constants for the coast distance map block.
package cdm_pkg;

  localparam int HEIGHT_W = 16;
  localparam int COORD_W  = 6;
  localparam int LEVEL_W  = 2;
  localparam int SIDE_CFG_W = 7;
  localparam int REG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_WATER_LEVEL = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MAP_SIDE    = 1'b1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [LEVEL_W-1:0] LAND_LEVEL = 2'd3;
  localparam logic [LEVEL_W-1:0] OPEN_LEVEL = 2'd0;

  // Scan passes over the map
  localparam logic [1:0] PASS_ROW_FWD = 2'd0;
  localparam logic [1:0] PASS_ROW_REV = 2'd1;
  localparam logic [1:0] PASS_COL_FWD = 2'd2;
  localparam logic [1:0] PASS_COL_REV = 2'd3;

  typedef struct packed {
    logic                kind;
    logic [HEIGHT_W-1:0] height;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  column;
  } req_t;

  typedef struct packed {
    logic               ready_res;
    logic [LEVEL_W-1:0] level;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic load_en;
    logic rd_en;
    logic scan_start;
    logic scan_step;
    logic pass_next;
    logic done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic load_last;
    logic scan_last;
    logic pass_last;
    logic rd_pend;
    logic out_busy;
  } ctrl_sts_t;

endpackage

[rtl/core/cdm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/cdm_ctrl.sv]
// Sequencer for loading, reads and the four decay passes.
module cdm_ctrl
  import cdm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_kind,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;
  logic   in_ready;
  logic   take;

  assign in_ready = (state == ST_IDLE) && !sts.rd_pend && !sts.out_busy;
  assign take     = in_ready && req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && req_kind == KIND_LOAD && sts.load_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = sts.pass_last ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.in_ready   = in_ready;
        cmd.load_en    = take && req_kind == KIND_LOAD;
        cmd.rd_en      = take && req_kind == KIND_READ;
        cmd.scan_start = take && req_kind == KIND_LOAD && sts.load_last;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_DRAIN: begin
        // last write of the pass lands here; no read is issued
        cmd.pass_next = !sts.pass_last;
        cmd.done      = sts.pass_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/core/cdm_datapath.sv]
// Height and distance stores, load and scan counters, decay logic, result register.
module cdm_datapath
  import cdm_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ctrl_cmd_t                          cmd,
  output ctrl_sts_t                          sts,
  input  req_t                               req,
  input  logic [$clog2(MAX_SIDE+1)-1:0]      side,
  input  logic [HEIGHT_W-1:0]                water_level,
  input  logic                               side_wr,
  output logic                               res_valid,
  input  logic                               res_ready,
  output res_t                               res
);

  localparam int IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int CW    = (SW > COORD_W) ? SW : COORD_W;
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;

  logic [IW-1:0] nm1;
  assign nm1 = IW'(side - SW'(1));

  // load position as row / column
  logic [IW-1:0] lrow, lcol;
  logic          map_ready;

  // scan state
  logic [1:0]    pass;
  logic [IW-1:0] sa, sb;
  logic [IW-1:0] srow, scol;
  logic [AW-1:0] scan_addr;

  // pipeline stage after the read
  logic          s1_valid, s1_first, s1_p0;
  logic [AW-1:0] s1_addr;
  logic [LEVEL_W-1:0] lvl;
  logic [HEIGHT_W-1:0] wl_build;

  // read item bookkeeping
  logic rd_pend, rd_ok, rd_rdy;

  logic [HEIGHT_W-1:0] h_rdata;
  logic [LEVEL_W-1:0]  d_rdata;
  logic [AW-1:0]       d_raddr;
  logic [AW-1:0]       rd_addr;
  logic                land;
  logic [LEVEL_W-1:0]  lvl_in, dec, wval;
  logic                in_map;

  assign sts.load_last = (lrow == nm1) && (lcol == nm1);
  assign sts.scan_last = (sa == nm1) && (sb == nm1);
  assign sts.pass_last = (pass == PASS_COL_REV);
  assign sts.rd_pend   = rd_pend;
  assign sts.out_busy  = res_valid && !res_ready;

  // load counters
  always_ff @(posedge clk) begin
    if (rst || side_wr) begin
      lrow <= '0;
      lcol <= '0;
    end else if (cmd.load_en) begin
      if (lcol == nm1) begin
        lcol <= '0;
        lrow <= (lrow == nm1) ? '0 : lrow + IW'(1);
      end else begin
        lcol <= lcol + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || side_wr) begin
      map_ready <= 1'b0;
    end else if (cmd.done) begin
      map_ready <= 1'b1;
    end
  end

  // scan counters: sa is the line, sb the step along it
  always_ff @(posedge clk) begin
    if (cmd.scan_start || cmd.pass_next) begin
      pass <= cmd.scan_start ? PASS_ROW_FWD : pass + 2'd1;
      sa   <= '0;
      sb   <= '0;
    end else if (cmd.scan_step) begin
      if (sb == nm1) begin
        sb <= '0;
        sa <= sa + IW'(1);
      end else begin
        sb <= sb + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      wl_build <= water_level;
    end
  end

  always_comb begin
    case (pass)
      PASS_ROW_FWD: begin
        srow = sa;
        scol = sb;
      end
      PASS_ROW_REV: begin
        srow = sa;
        scol = nm1 - sb;
      end
      PASS_COL_FWD: begin
        srow = sb;
        scol = sa;
      end
      default: begin
        srow = nm1 - sb;
        scol = sa;
      end
    endcase
  end

  assign scan_addr = {srow, scol};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr  <= scan_addr;
    s1_first <= (sb == '0);
    s1_p0    <= (pass == PASS_ROW_FWD);
  end

  // decay step; after the first pass a land cell is the only one holding 3
  assign land   = s1_p0 ? (h_rdata >= wl_build) : (d_rdata == LAND_LEVEL);
  assign lvl_in = s1_first ? OPEN_LEVEL : lvl;
  assign dec    = (lvl_in == OPEN_LEVEL) ? OPEN_LEVEL : lvl_in - LEVEL_W'(1);

  always_comb begin
    if (land) begin
      wval = LAND_LEVEL;
    end else if (s1_p0) begin
      wval = dec;
    end else begin
      wval = (dec > d_rdata) ? dec : d_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      lvl <= land ? LAND_LEVEL : dec;
    end
  end

  // read items
  assign rd_addr = {IW'(req.row), IW'(req.column)};
  assign d_raddr = cmd.rd_en ? rd_addr : scan_addr;
  assign in_map  = (CW'(req.row) < CW'(side)) && (CW'(req.column) < CW'(side));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_ok  <= map_ready && in_map;
      rd_rdy <= map_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rd_pend) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      res.ready_res <= rd_rdy;
      res.level     <= rd_ok ? d_rdata : OPEN_LEVEL;
    end
  end

  cdm_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (DEPTH)
  ) u_height_ram (
    .clk   (clk),
    .we    (cmd.load_en),
    .waddr ({lrow, lcol}),
    .wdata (req.height),
    .raddr (scan_addr),
    .rdata (h_rdata)
  );

  cdm_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (DEPTH)
  ) u_distance_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (wval),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

endmodule

[rtl/core/coast_distance_map.sv]
// Top level of the coast distance map: configuration registers and core wiring.
//
// Load transfers (kind 0) write one height sample each, row-major, one per
// cycle while the block is idle. The load that completes the side x side map
// starts a build of four decay passes (rows forward, rows reverse, columns
// forward, columns reverse), one cell per cycle through the single read port
// of the distance RAM, each pass followed by a drain state; no transfer is
// accepted during the build. A read transfer (kind 1) returns its result
// through a pending flag and then the result register, and the next item is
// taken once that result is registered and the result register is free.
// Writing map_side restarts loading and clears the ready flag; water_level
// is sampled when a build starts. No clearing pass is needed after reset.
module coast_distance_map
  import cdm_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // item channel
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  // result channel
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res,
  // configuration writes
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = (SW > SIDE_CFG_W) ? SW : SIDE_CFG_W;

  logic [HEIGHT_W-1:0]   water_level;
  logic [SIDE_CFG_W-1:0] map_side;
  logic [SW-1:0]         side;
  logic                  side_wr;
  ctrl_cmd_t             cmd;
  ctrl_sts_t             sts;

  assign side_wr = wr_en && (wr_index == REG_MAP_SIDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      water_level <= 16'd0;
      map_side    <= 7'd64;
    end else if (wr_en) begin
      case (wr_index)
        REG_WATER_LEVEL: water_level <= wr_data;
        REG_MAP_SIDE:    map_side    <= wr_data[SIDE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective side: 0 acts as 1, anything past MAX_SIDE is clamped
  always_comb begin
    if (map_side == '0) begin
      side = SW'(1);
    end else if (CW'(map_side) > CW'(MAX_SIDE)) begin
      side = SW'(MAX_SIDE);
    end else begin
      side = SW'(map_side);
    end
  end

  assign req_ready = cmd.in_ready;

  cdm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (req.kind),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdm_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req         (req),
    .side        (side),
    .water_level (water_level),
    .side_wr     (side_wr),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

endmodule
